// ===== rtl/msa_pkg.sv =====
package msa_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned BinsDefault      = 2048;
  localparam int unsigned CountBitsDefault = 32;

  // Field widths (fixed by the stream format)
  localparam int unsigned ReadBinW    = 11;
  localparam int unsigned ReadValueW  = 32;
  localparam int unsigned SweepCountW = 32;
  localparam int unsigned CurBinW     = 11;

  // Packed stream words, padded to whole bytes
  localparam int unsigned InDataW  = 16;  // start, gate, pulse, read_bin
  localparam int unsigned OutDataW = 80;  // read_value, sweep_done, sweep_count, current_bin

  // Output word bit positions
  localparam int unsigned OutDoneBit  = ReadValueW;
  localparam int unsigned OutSweepLsb = ReadValueW + 1;
  localparam int unsigned OutBinLsb   = OutSweepLsb + SweepCountW;

  // Input item kind (tuser)
  typedef enum logic {
    ActSample = 1'b0,
    ActRead   = 1'b1
  } action_e;

  typedef struct packed {
    logic [CurBinW-1:0]     current_bin;
    logic [SweepCountW-1:0] sweep_count;
    logic                   sweep_done;
    logic [ReadValueW-1:0]  read_value;
  } out_word_t;

endpackage

// ===== rtl/multichannel_scaler_accumulator.sv =====
// Multichannel scaler with accumulating bins. Each input word is either a
// sample of the start, gate and pulse lines (tuser = 0) or a read request for
// one bin (tuser = 1); every input word yields exactly one output word, in
// order. While start and gate are high, rising edges of the pulse line are
// counted; when the gate window closes (or start drops inside it) the count is
// added, saturating, into the current bin and the bin index advances. After
// BINS bins the sweep counter increments, the index wraps and sweep_done is set
// on that word. Bins live in one BINS x COUNT_BITS synchronous RAM and are
// cleared only by reset: after rst_ni rises the block runs a clearing pass
// over all BINS entries (one entry per cycle), holding s_axis_tready low.
// After that it takes one word per clock, sustained, as long as the output
// side drains; the single RAM read port (issued when a word is accepted) and
// the one read-modify-write stage behind it set that rate. An accepted word
// passes stage 1 into a 4-deep output queue that lets the block keep
// accepting while results wait; a bin written by the previous word is
// forwarded around the RAM so back-to-back accesses see the fresh count.
module multichannel_scaler_accumulator #(
  parameter int unsigned BINS       = msa_pkg::BinsDefault,
  parameter int unsigned COUNT_BITS = msa_pkg::CountBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: [0] start_level, [1] gate_level, [2] pulse_level, [13:3] read_bin
  input  logic [msa_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: [0] action
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: [31:0] read_value, [32] sweep_done, [64:33] sweep_count,
  //        [75:65] current_bin, [79:76] zero
  output logic [msa_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready
);

  localparam int unsigned IW   = $clog2(BINS);
  localparam int unsigned CW   = COUNT_BITS;
  localparam int unsigned RbW  = msa_pkg::ReadBinW;
  localparam int unsigned QD   = 4;
  localparam logic [IW-1:0] LastBin = IW'(BINS - 1);

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic           in_fire;
  logic           in_start, in_gate, in_pulse;
  logic [RbW-1:0] in_rbin;
  logic           in_is_read;
  logic [IW+RbW-1:0] rb_ext;
  logic [IW-1:0]  rb_addr;
  logic           rb_in_range;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign in_start   = s_axis_tdata[0];
  assign in_gate    = s_axis_tdata[1];
  assign in_pulse   = s_axis_tdata[2];
  assign in_rbin    = s_axis_tdata[3 +: RbW];
  assign in_is_read = (msa_pkg::action_e'(s_axis_tuser) == msa_pkg::ActRead);

  // read_bin widened to cover any bin index width, then trimmed to an address
  assign rb_ext      = {{IW{1'b0}}, in_rbin};
  assign rb_addr     = rb_ext[IW-1:0];
  assign rb_in_range = (rb_ext < (IW+RbW)'(BINS));

  // ---------------------------------------------------------------------------
  // Scaler control state (flip-flops)
  // ---------------------------------------------------------------------------
  logic [IW-1:0]  ptr_q, ptr_d;
  logic [CW-1:0]  win_cnt_q, win_cnt_d;
  logic           win_open_q, win_open_d;
  logic           prev_pulse_q, prev_pulse_d;
  logic [31:0]    sweeps_q, sweeps_d;
  logic           commit;     // this sample closes a window
  logic           done;       // this sample closes the last bin of a sweep
  logic           rising;

  always_comb begin
    ptr_d        = ptr_q;
    win_cnt_d    = win_cnt_q;
    win_open_d   = win_open_q;
    prev_pulse_d = prev_pulse_q;
    sweeps_d     = sweeps_q;
    commit       = 1'b0;
    done         = 1'b0;
    rising       = in_pulse && !prev_pulse_q;
    if (in_fire && !in_is_read) begin
      prev_pulse_d = in_pulse;
      if (in_start && in_gate) begin
        win_open_d = 1'b1;
        if (rising && (win_cnt_q != '1)) begin
          win_cnt_d = win_cnt_q + CW'(1);
        end
      end else if (win_open_q) begin
        commit     = 1'b1;
        win_open_d = 1'b0;
        win_cnt_d  = '0;
        if (ptr_q == LastBin) begin
          ptr_d    = '0;
          sweeps_d = sweeps_q + 32'd1;
          done     = 1'b1;
        end else begin
          ptr_d = ptr_q + IW'(1);
        end
      end
      if (!in_start) begin
        ptr_d      = '0;
        win_cnt_d  = '0;
        win_open_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q        <= '0;
      win_cnt_q    <= '0;
      win_open_q   <= 1'b0;
      prev_pulse_q <= 1'b0;
      sweeps_q     <= '0;
    end else begin
      ptr_q        <= ptr_d;
      win_cnt_q    <= win_cnt_d;
      win_open_q   <= win_open_d;
      prev_pulse_q <= prev_pulse_d;
      sweeps_q     <= sweeps_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass after reset
  // ---------------------------------------------------------------------------
  logic          clr_busy_q;
  logic [IW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + IW'(1);
      if (clr_addr_q == LastBin) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: RAM data back, read-modify-write of the committed bin
  // ---------------------------------------------------------------------------
  logic              s1_valid_q;
  logic              s1_is_read_q, s1_commit_q, s1_in_range_q, s1_done_q;
  logic [IW-1:0]     s1_addr_q;
  logic [CW-1:0]     s1_add_q;
  logic [31:0]       s1_sweeps_q;
  logic [IW-1:0]     s1_ptr_q;
  logic              fwd_hit_q;
  logic [CW-1:0]     fwd_data_q;
  logic [CW-1:0]     mem_rd_q;

  logic [IW-1:0]     raddr;
  logic [CW-1:0]     old_cnt;
  logic [CW:0]       sum;
  logic [CW-1:0]     new_cnt;
  logic              s1_wr;
  logic              mem_we;
  logic [IW-1:0]     waddr;
  logic [CW-1:0]     wdata;

  assign raddr   = in_is_read ? rb_addr : ptr_q;
  assign old_cnt = fwd_hit_q ? fwd_data_q : mem_rd_q;
  assign sum     = {1'b0, old_cnt} + {1'b0, s1_add_q};
  assign new_cnt = sum[CW] ? '1 : sum[CW-1:0];   // saturate
  assign s1_wr   = s1_valid_q && s1_commit_q;

  assign mem_we = clr_busy_q || s1_wr;
  assign waddr  = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign wdata  = clr_busy_q ? '0 : new_cnt;

  // Bin RAM: one write port, one registered read port (old data on collision)
  logic [CW-1:0] bin_mem [BINS];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bin_mem[waddr] <= wdata;
    end
    if (in_fire) begin
      mem_rd_q <= bin_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      if (in_fire) begin
        // the word in stage 1 writes this same bin now: RAM read is stale
        fwd_hit_q <= s1_wr && (raddr == s1_addr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_is_read_q  <= in_is_read;
      s1_commit_q   <= commit;
      s1_in_range_q <= rb_in_range;
      s1_done_q     <= done;
      s1_addr_q     <= raddr;
      s1_add_q      <= win_cnt_q;
      s1_sweeps_q   <= sweeps_d;
      s1_ptr_q      <= ptr_d;
      fwd_data_q    <= new_cnt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result word
  // ---------------------------------------------------------------------------
  logic [CW+31:0]       val_ext;
  logic [IW+10:0]       bin_ext;
  msa_pkg::out_word_t   res;

  assign val_ext = {32'b0, old_cnt};
  assign bin_ext = {11'b0, s1_ptr_q};

  always_comb begin
    res.read_value  = (s1_is_read_q && s1_in_range_q) ? val_ext[31:0] : '0;
    res.sweep_done  = s1_done_q;
    res.sweep_count = s1_sweeps_q;
    res.current_bin = bin_ext[10:0];
  end

  // ---------------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------------
  localparam int unsigned QW = $clog2(QD);

  logic [msa_pkg::OutDataW-1:0] q_mem_q [QD];
  logic [QW-1:0]                q_wr_q, q_rd_q;
  logic [QW:0]                  q_cnt_q;
  logic                         q_pop;
  logic [QW+1:0]                inflight;

  assign q_pop    = m_axis_tvalid && m_axis_tready;
  assign inflight = (QW+2)'(q_cnt_q) + (QW+2)'(s1_valid_q);

  // room for the word in stage 1 and the one accepted now
  assign s_axis_tready = !clr_busy_q && (inflight < (QW+2)'(QD));
  assign m_axis_tvalid = (q_cnt_q != '0);
  assign m_axis_tdata  = q_mem_q[q_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      if (s1_valid_q) begin
        q_wr_q <= q_wr_q + QW'(1);
      end
      if (q_pop) begin
        q_rd_q <= q_rd_q + QW'(1);
      end
      q_cnt_q <= q_cnt_q + (QW+1)'(s1_valid_q) - (QW+1)'(q_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      q_mem_q[q_wr_q] <= {{(msa_pkg::OutDataW - $bits(res)){1'b0}}, res};
    end
  end

endmodule

// ===== rtl/msa_checker.sv =====
module msa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [msa_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready
);

  logic                              out_fire;
  logic                              o_done;
  logic [msa_pkg::SweepCountW-1:0]   o_sweeps;
  logic [msa_pkg::CurBinW-1:0]       o_bin;
  logic [msa_pkg::ReadValueW-1:0]    o_value;
  logic [msa_pkg::SweepCountW-1:0]   last_sweeps_q;

  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign o_value  = m_axis_tdata[msa_pkg::ReadValueW-1:0];
  assign o_done   = m_axis_tdata[msa_pkg::OutDoneBit];
  assign o_sweeps = m_axis_tdata[msa_pkg::OutSweepLsb +: msa_pkg::SweepCountW];
  assign o_bin    = m_axis_tdata[msa_pkg::OutBinLsb +: msa_pkg::CurBinW];

  // sweep count seen on the last delivered word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sweeps_q <= '0;
    end else if (out_fire) begin
      last_sweeps_q <= o_sweeps;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_done_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_done |-> (o_bin == '0) && (o_value == '0))
    else $error("sweep end without wrapped index or with read value");

  a_sweep_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> o_sweeps == last_sweeps_q + msa_pkg::SweepCountW'(o_done))
    else $error("sweep count moved without sweep_done");

  a_no_accept_in_reset_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input accepted before bin clearing");

endmodule

bind multichannel_scaler_accumulator msa_checker u_msa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// ===== dv/scaler_result_check.sv =====
// Watches both stream ports, keeps its own copy of the bin counts, window and
// sweep state, and compares every output word with the oldest owed prediction.
module scaler_result_check import msa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output int                  mismatches_o,
  output int                  owed_o
);

  localparam int unsigned Bins       = BinsDefault;
  localparam int unsigned CountBits  = CountBitsDefault;
  localparam int          WordW      = $bits(out_word_t);

  typedef logic [CountBits-1:0] count_t;

  count_t      bin_counts [Bins];
  int unsigned bin_ptr;
  count_t      window_count;
  logic        window_open;
  logic        last_pulse;
  logic [SweepCountW-1:0] sweep_total;

  out_word_t owed_words [$];
  out_word_t got_word;
  out_word_t want_word;
  int        mismatch_count;
  int        words_seen;

  assign mismatches_o = mismatch_count;

  function automatic count_t sat_add(count_t a, count_t b);
    logic [CountBits:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CountBits] ? '1 : sum[CountBits-1:0];
  endfunction

  // Advances the scaler state by one input word and returns the word it owes.
  function automatic out_word_t predict_word(action_e act, logic start_lvl, logic gate_lvl,
                                             logic pulse_lvl, logic [ReadBinW-1:0] rd_bin);
    out_word_t w;
    logic      rising;
    w = '0;
    if (act == ActRead) begin
      if (rd_bin < Bins) w.read_value = bin_counts[rd_bin][ReadValueW-1:0];
    end else begin
      // edge detect tracks every sample, whatever start and gate are
      rising     = pulse_lvl && !last_pulse;
      last_pulse = pulse_lvl;
      if (start_lvl && gate_lvl) begin
        window_open = 1'b1;
        if (rising) window_count = sat_add(window_count, count_t'(1));
      end else if (window_open) begin
        // window closes: commit, even when empty, and step the bin index
        if (bin_ptr < Bins) bin_counts[bin_ptr] = sat_add(bin_counts[bin_ptr], window_count);
        bin_ptr++;
        if (bin_ptr >= Bins) begin
          bin_ptr      = 0;
          sweep_total++;
          w.sweep_done = 1'b1;
        end
        window_open  = 1'b0;
        window_count = '0;
      end
      if (!start_lvl) begin
        bin_ptr      = 0;
        window_count = '0;
        window_open  = 1'b0;
      end
    end
    w.sweep_count = sweep_total;
    w.current_bin = CurBinW'(bin_ptr);
    return w;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got_v, logic [63:0] want_v);
    mismatch_count++;
    $display("word %0d: %s got 0x%0h, expected 0x%0h", words_seen, field, got_v, want_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (bin_counts[i]) bin_counts[i] = '0;
      bin_ptr        = 0;
      window_count   = '0;
      window_open    = 1'b0;
      last_pulse     = 1'b0;
      sweep_total    = '0;
      mismatch_count = 0;
      words_seen     = 0;
      owed_words.delete();
      owed_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        owed_words.push_back(predict_word(action_e'(s_axis_tuser), s_axis_tdata[0],
                                          s_axis_tdata[1], s_axis_tdata[2],
                                          s_axis_tdata[3 +: ReadBinW]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_word = out_word_t'(m_axis_tdata[WordW-1:0]);
        if (owed_words.size() == 0) begin
          report_mismatch("word with nothing owed, read_value", got_word.read_value, '0);
        end else begin
          want_word = owed_words.pop_front();
          if (got_word.read_value !== want_word.read_value)
            report_mismatch("read_value", got_word.read_value, want_word.read_value);
          if (got_word.sweep_done !== want_word.sweep_done)
            report_mismatch("sweep_done", got_word.sweep_done, want_word.sweep_done);
          if (got_word.sweep_count !== want_word.sweep_count)
            report_mismatch("sweep_count", got_word.sweep_count, want_word.sweep_count);
          if (got_word.current_bin !== want_word.current_bin)
            report_mismatch("current_bin", got_word.current_bin, want_word.current_bin);
          if (m_axis_tdata[OutDataW-1:WordW] !== '0)
            report_mismatch("pad bits", m_axis_tdata[OutDataW-1:WordW], '0);
        end
        words_seen++;
      end
      owed_o <= owed_words.size();
    end
  end

endmodule

// ===== dv/multichannel_scaler_accumulator_test.sv =====
// Stimulus and verdict for the multichannel scaler. Prediction and compare
// live in scaler_result_check; this module drives the stream ports, runs a watchdog and prints the verdict.
module multichannel_scaler_accumulator_test;
  import msa_pkg::*;

  localparam int IdlePct       = 37;     // chance per cycle that a side idles
  localparam int RandomItems   = 1250;
  localparam int RxHoldCycles  = 400;    // long output stall, fills the block
  localparam int WatchdogLimit = 20000;  // covers the clearing pass after reset
  localparam int SettleCycles  = 16;

  logic                clk;
  logic                rst_n         = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  wire                 s_axis_tready;
  wire [OutDataW-1:0]  m_axis_tdata;
  wire                 m_axis_tvalid;
  logic                m_axis_tready = 1'b0;

  int mismatches;
  int owed;          // words predicted but not yet seen, as a registered count
  int items_sent     = 0;
  int stall_cycles   = 0;

  bit tx_steady   = 1'b0;  // sender offers every cycle
  bit rx_steady   = 1'b0;  // receiver takes every cycle
  bit rx_hold_req = 1'b0;  // ask the receiver for one long stall

  multichannel_scaler_accumulator #(
    .BINS      (BinsDefault),
    .COUNT_BITS(CountBitsDefault)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  scaler_result_check result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .mismatches_o (mismatches),
    .owed_o       (owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Nothing accepted on either side for too long: the block is hung.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("watchdog: no word moved for %0d cycles", stall_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: random backpressure, one long hold on request. The hold is
  // counted here so the sender keeps offering while the block fills up.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RxHoldCycles - 1) @(posedge clk);
      end else begin
        m_axis_tready <= rx_steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  function automatic logic coin();
    return logic'($urandom_range(1));
  endfunction

  // Offer one word, hold it until taken, then maybe idle a few cycles.
  // Called right after a rising edge; valid is never dropped and raised in
  // the same step.
  task automatic push_word(action_e act, logic start_lvl, logic gate_lvl, logic pulse_lvl,
                           logic [ReadBinW-1:0] rd_bin);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= logic'(act);
    s_axis_tdata  <= {{(InDataW - ReadBinW - 3){1'b0}}, rd_bin, pulse_lvl, gate_lvl, start_lvl};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    while (!tx_steady && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= InDataW'($urandom);  // junk on the bus while idle
      @(posedge clk);
    end
  endtask

  // Sample word; read_bin is junk here so its bits toggle on samples too.
  task automatic sample(logic start_lvl, logic gate_lvl, logic pulse_lvl);
    push_word(ActSample, start_lvl, gate_lvl, pulse_lvl, ReadBinW'($urandom));
  endtask

  // Read word; the line levels are junk and must not matter.
  task automatic read_word(int unsigned bin);
    push_word(ActRead, coin(), coin(), coin(), ReadBinW'(bin));
  endtask

  // Stop offering and wait for every owed word. The first edge lets the
  // owed count catch up with the last accepted word.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  // One random stretch: mostly well-formed window trains with start held
  // high and reads mixed in, the rest fully random words.
  task automatic random_run();
    int windows;
    if ($urandom_range(99) < 72) begin
      windows = $urandom_range(1, 8);
      for (int w = 0; w < windows; w++) begin
        repeat ($urandom_range(1, 6)) begin
          sample(1'b1, 1'b1, coin());
          if ($urandom_range(99) < 8)
            read_word(coin() ? $urandom_range(0, 15) : $urandom_range(0, 2047));
        end
        if (w == windows - 1 && $urandom_range(99) < 20)
          sample(1'b0, coin(), coin());   // start drops with the window open
        else
          repeat ($urandom_range(1, 3)) sample(1'b1, 1'b0, coin());
      end
      if ($urandom_range(99) < 25) sample(1'b0, coin(), coin());
    end else begin
      repeat ($urandom_range(1, 10))
        push_word(action_e'($urandom_range(1)), coin(), coin(), coin(), ReadBinW'($urandom));
    end
  endtask

  initial begin
    int rand_base;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // fresh store reads zero, lowest and highest index
    read_word(0);
    read_word(2047);
    // start low: pulse edges are tracked but nothing opens
    sample(1'b0, 1'b0, 1'b0);
    sample(1'b0, 1'b1, 1'b1);
    // window opens with pulse already high: no edge
    sample(1'b1, 1'b1, 1'b1);
    sample(1'b1, 1'b1, 1'b0);
    sample(1'b1, 1'b1, 1'b1);   // edge
    sample(1'b1, 1'b1, 1'b1);   // held high, no edge
    sample(1'b1, 1'b1, 1'b0);
    read_word(0);               // read in mid-window leaves edge history alone
    sample(1'b1, 1'b1, 1'b1);   // edge across the read
    sample(1'b1, 1'b0, 1'b0);   // gate falls: bin 0 gets 2
    sample(1'b1, 1'b0, 1'b1);   // pulse rises outside any window
    // empty window still commits and advances
    sample(1'b1, 1'b1, 1'b1);
    sample(1'b1, 1'b0, 1'b0);
    // start drops inside a window: commit first, then index back to zero
    sample(1'b1, 1'b1, 1'b0);
    sample(1'b1, 1'b1, 1'b1);
    sample(1'b0, 1'b1, 1'b0);
    sample(1'b0, 1'b0, 1'b1);
    read_word(0);
    read_word(1);
    read_word(2);
    read_word(1024);
    // bin 0 accumulates on top of its earlier count
    sample(1'b1, 1'b1, 1'b0);
    sample(1'b1, 1'b1, 1'b1);
    sample(1'b1, 1'b0, 1'b1);
    read_word(0);

    // --- full sweep: every bin once, wrap, sweep_done, count one ---
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    sample(1'b0, 1'b0, 1'b0);
    sample(1'b1, 1'b0, coin());
    for (int w = 0; w < BinsDefault; w++) begin
      if (w == BinsDefault / 2) begin
        tx_steady = 1'b0;
        rx_steady = 1'b0;
      end
      sample(1'b1, 1'b1, coin());
      if ($urandom_range(99) < 30) sample(1'b1, 1'b1, coin());
      sample(1'b1, 1'b0, coin());
      if ($urandom_range(99) < 2) read_word($urandom_range(0, 2047));
    end
    sample(1'b1, 1'b1, 1'b1);
    sample(1'b1, 1'b0, 1'b0);
    read_word(0);
    read_word(BinsDefault - 1);
    sample(1'b0, 1'b0, 1'b0);

    // --- random ---
    rand_base = items_sent;
    for (int run = 0; items_sent < rand_base + RandomItems; run++) begin
      if (run == 8) begin
        // receiver stalls long while the sender keeps offering every cycle
        rx_hold_req = 1'b1;
        tx_steady   = 1'b1;
      end
      if (run == 12) tx_steady = 1'b0;
      if (run == 20) wait_drained();   // sender pauses until all words are back
      if (run == 30) begin
        tx_steady = 1'b1;
        rx_steady = 1'b1;
      end
      if (run == 42) begin
        tx_steady = 1'b0;
        rx_steady = 1'b0;
      end
      random_run();
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && owed == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
